### rtl/core/stvk_pkg.sv
// stvk_pkg: shared types, register indexes and rounding helper for the
// st venant-kirchhoff energy, stress and hessian block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package stvk_pkg;

    localparam int OUT_W  = 48;
    localparam int COEF_W = 24;

    localparam logic       CFG_LAMBDA = 1'b0;
    localparam logic       CFG_MU     = 1'b1;
    localparam logic [1:0] COL_LAST   = 2'd3;

    localparam logic [COEF_W-1:0] LAMBDA_RST = 24'd93623;
    localparam logic [COEF_W-1:0] MU_RST     = 24'd23406;

    typedef logic signed [15:0] t_fval;

    typedef struct packed {
        logic [COEF_W-1:0] lam;
        logic [COEF_W-1:0] mu;
    } t_cfg;

    // f holds vec(F): index row + 2*col
    typedef struct packed {
        logic [3:0][15:0]       f;
        logic signed [33:0]     e00;
        logic signed [33:0]     e01;
        logic signed [33:0]     e11;
        logic signed [33:0]     b00;
        logic signed [33:0]     b01;
        logic signed [33:0]     b11;
        logic signed [34:0]     tr;
        logic [OUT_W-1:0]       energy;
        logic                   esat;
        logic [3:0][OUT_W-1:0]  stress;
        logic [3:0]             ssat;
    } t_item;

    typedef struct packed {
        logic [OUT_W-1:0] val;
        logic             sat;
    } t_rs;

    localparam logic signed [127:0] MAX48 = 128'sh7FFF_FFFF_FFFF;
    localparam logic signed [127:0] MIN48 = -128'sh8000_0000_0000;

    // round half up at bit s, clamp to 48 bits
    function automatic t_rs round_sat(input logic signed [127:0] v, input int unsigned s);
        logic signed [127:0] t;
        t_rs r;
        t = v + ({{127{1'b0}}, 1'b1} << (s - 1));
        t = t >>> s;
        if (t > MAX48) begin
            r.val = 48'h7FFF_FFFF_FFFF;
            r.sat = 1'b1;
        end else if (t < MIN48) begin
            r.val = 48'h8000_0000_0000;
            r.sat = 1'b1;
        end else begin
            r.val = t[OUT_W-1:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/core/stvk_energy_stress_hessian_2d.sv
// stvk_energy_stress_hessian_2d: top level, config registers, front, queue, back
// depends on stvk_pkg, stvk_front, stvk_queue, stvk_back
//
// input stream: one beat per deformation gradient F, four signed Q4.12
// entries in column-major order in i_s_tdata
// output stream: four beats per input, one per hessian column, each with
// that column, the matching stress entry and the energy in Q31.16;
// tlast marks column 3, tuser flags a clamped value
// config port: i_cfg_we writes i_cfg_data into lambda (index 0) or mu
// (index 1) in the same cycle; write only while the block is idle
// latency: first beat of an item valid 8 cycles after its input beat is
// accepted
// throughput: one item per 4 cycles, set by the four output beats from
// the column sequencer in the back part
// the front pipeline keeps taking items while the queue has room, so an
// output stall holds the output register and fills the queue before
// o_s_tready drops
// reset: synchronous, clears all valid state and loads the default
// lame parameters
`timescale 1ns / 1ps
`default_nettype none
module stvk_energy_stress_hessian_2d #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic           i_cfg_index,
    input  wire logic [23:0]    i_cfg_data,
    input  wire logic           i_s_tvalid,
    output logic                o_s_tready,
    // f_row0_col0, f_row1_col0, f_row0_col1, f_row1_col1
    input  wire logic [63:0]    i_s_tdata,
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    // column_index, hess_entry0..3, stress_entry, energy, zero pad
    output logic [295:0]        o_m_tdata,
    // saturated
    output logic                o_m_tuser,
    output logic                o_m_tlast
);
    import stvk_pkg::*;

    t_cfg  r_cfg;
    t_item f_item, q_item;
    logic  push, pop, full, empty;
    logic [1:0] col;
    logic [3:0][47:0] hess;
    logic [47:0] stress, energy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lam <= LAMBDA_RST;
            r_cfg.mu  <= MU_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LAMBDA: r_cfg.lam <= i_cfg_data;
                CFG_MU:     r_cfg.mu  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    stvk_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .o_push  (push),
        .o_item  (f_item),
        .i_full  (full)
    );

    stvk_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_item  (q_item),
        .o_empty (empty)
    );

    stvk_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (q_item),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_col    (col),
        .o_hess   (hess),
        .o_stress (stress),
        .o_energy (energy),
        .o_sat    (o_m_tuser),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = {6'd0, energy, stress, hess[3], hess[2], hess[1], hess[0], col};
endmodule
`default_nettype wire

### rtl/core/stvk_ram_free_queue_placeholder.sv
// stvk_queue_ctl: occupancy bookkeeping for the item queue
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
module stvk_queue_ctl #(
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic                       i_pop,
    output logic [$clog2(DEPTH)-1:0]        o_wr_ptr,
    output logic [$clog2(DEPTH)-1:0]        o_rd_ptr,
    output logic                            o_full,
    output logic                            o_empty
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_wr_ptr = r_wr;
    assign o_rd_ptr = r_rd;
    assign o_full   = (r_cnt == CNT_FULL);
    assign o_empty  = (r_cnt == '0);
endmodule
`default_nettype wire

### rtl/core/stvk_queue.sv
// stvk_queue: short item queue between front and back
// depends on stvk_pkg and stvk_queue_ctl
`timescale 1ns / 1ps
`default_nettype none
module stvk_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  stvk_pkg::t_item     i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output stvk_pkg::t_item     o_item,
    output logic                o_empty
);
    import stvk_pkg::*;

    logic [$clog2(DEPTH)-1:0] wr_ptr, rd_ptr;
    t_item r_mem [DEPTH];

    stvk_queue_ctl #(.DEPTH(DEPTH)) u_ctl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_pop    (i_pop),
        .o_wr_ptr (wr_ptr),
        .o_rd_ptr (rd_ptr),
        .o_full   (o_full),
        .o_empty  (o_empty)
    );

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[wr_ptr] <= i_item;
    end

    assign o_item = r_mem[rd_ptr];
endmodule
`default_nettype wire

### rtl/core/stvk_front.sv
// stvk_front: accepts F, forms strain, trace, energy and stress in a stalling pipeline
// depends on stvk_pkg
`timescale 1ns / 1ps
`default_nettype none
module stvk_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  stvk_pkg::t_cfg      i_cfg,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire logic [63:0]    i_data,
    output logic                o_push,
    output stvk_pkg::t_item     o_item,
    input  wire logic           i_full
);
    import stvk_pkg::*;

    localparam logic signed [33:0] E_ONE = 34'sd16777216;

    logic en;
    logic r_v0, r_v1, r_v2, r_v3, r_v4;

    logic [3:0][15:0] r0_f, r1_f, r2_f, r3_f;
    logic signed [33:0] r1_e00, r1_e01, r1_e11, r1_b00, r1_b01, r1_b11;
    logic signed [33:0] r2_e00, r2_e01, r2_e11, r2_b00, r2_b01, r2_b11;
    logic signed [33:0] r3_e00, r3_e01, r3_e11, r3_b00, r3_b01, r3_b11;
    logic signed [34:0] r2_tr, r3_tr;
    logic signed [69:0] r2_tsq, r2_ssq;
    logic signed [50:0] r2_fe [4];
    logic signed [50:0] r2_tf [4];
    logic signed [59:0] r3_lt_hi, r3_ms_hi;
    logic signed [60:0] r3_lt_lo, r3_ms_lo;
    logic signed [49:0] r3_mf_hi [4];
    logic signed [51:0] r3_mf_lo [4];
    logic signed [49:0] r3_lf_hi [4];
    logic signed [51:0] r3_lf_lo [4];
    t_item r4_item;

    logic signed [33:0] n1_e00, n1_e01, n1_e11, n1_b00, n1_b01, n1_b11;
    logic signed [34:0] n2_tr;
    logic signed [69:0] n2_tsq, n2_ssq;
    logic signed [50:0] n2_fe [4];
    logic signed [50:0] n2_tf [4];
    logic signed [59:0] n3_lt_hi, n3_ms_hi;
    logic signed [60:0] n3_lt_lo, n3_ms_lo;
    logic signed [49:0] n3_mf_hi [4];
    logic signed [51:0] n3_mf_lo [4];
    logic signed [49:0] n3_lf_hi [4];
    logic signed [51:0] n3_lf_lo [4];
    t_item n4_item;

    logic signed [24:0] cl, cm;
    assign cl = $signed({1'b0, i_cfg.lam});
    assign cm = $signed({1'b0, i_cfg.mu});

    assign en      = !(r_v4 && i_full);
    assign o_ready = en;
    assign o_push  = r_v4 && !i_full;
    assign o_item  = r4_item;

    // strain and left cauchy-green terms
    always_comb begin
        logic signed [15:0] f00, f10, f01, f11;
        logic signed [31:0] pa, pb, pc, pd, pe, pg, ph, pi;
        f00 = $signed(r0_f[0]);
        f10 = $signed(r0_f[1]);
        f01 = $signed(r0_f[2]);
        f11 = $signed(r0_f[3]);
        pa = f00 * f00;
        pb = f10 * f10;
        pc = f00 * f01;
        pd = f10 * f11;
        pe = f01 * f01;
        pg = f11 * f11;
        ph = f00 * f10;
        pi = f01 * f11;
        n1_e00 = pa + pb - E_ONE;
        n1_e01 = pc + pd;
        n1_e11 = pe + pg - E_ONE;
        n1_b00 = pa + pe;
        n1_b01 = ph + pi;
        n1_b11 = pb + pg;
    end

    // trace, squares, F*E and tr*F
    always_comb begin
        logic signed [67:0] q0, q1, q2;
        logic signed [15:0] f00, f10, f01, f11;
        logic signed [49:0] t0, t1;
        f00 = $signed(r1_f[0]);
        f10 = $signed(r1_f[1]);
        f01 = $signed(r1_f[2]);
        f11 = $signed(r1_f[3]);
        n2_tr  = r1_e00 + r1_e11;
        n2_tsq = n2_tr * n2_tr;
        q0 = r1_e00 * r1_e00;
        q1 = r1_e01 * r1_e01;
        q2 = r1_e11 * r1_e11;
        n2_ssq = q0 + q1 + q1 + q2;
        t0 = f00 * r1_e00; t1 = f01 * r1_e01; n2_fe[0] = t0 + t1;
        t0 = f10 * r1_e00; t1 = f11 * r1_e01; n2_fe[1] = t0 + t1;
        t0 = f00 * r1_e01; t1 = f01 * r1_e11; n2_fe[2] = t0 + t1;
        t0 = f10 * r1_e01; t1 = f11 * r1_e11; n2_fe[3] = t0 + t1;
        for (int n = 0; n < 4; n++) begin
            n2_tf[n] = n2_tr * $signed(r1_f[n]);
        end
    end

    // split coefficient products
    always_comb begin
        n3_lt_hi = $signed(r2_tsq[69:35]) * cl;
        n3_lt_lo = $signed({1'b0, r2_tsq[34:0]}) * cl;
        n3_ms_hi = $signed(r2_ssq[69:35]) * cm;
        n3_ms_lo = $signed({1'b0, r2_ssq[34:0]}) * cm;
        for (int n = 0; n < 4; n++) begin
            n3_mf_hi[n] = $signed(r2_fe[n][50:26]) * cm;
            n3_mf_lo[n] = $signed({1'b0, r2_fe[n][25:0]}) * cm;
            n3_lf_hi[n] = $signed(r2_tf[n][50:26]) * cl;
            n3_lf_lo[n] = $signed({1'b0, r2_tf[n][25:0]}) * cl;
        end
    end

    // sums, rounding and clamp
    always_comb begin
        logic signed [99:0] al, am, ae;
        logic signed [79:0] sm, sl, sa;
        t_rs rs;
        al = r3_lt_hi;
        al = (al <<< 35) + r3_lt_lo;
        am = r3_ms_hi;
        am = (am <<< 35) + r3_ms_lo;
        ae = al + am + am;
        rs = round_sat(ae, 49);
        n4_item.energy = rs.val;
        n4_item.esat   = rs.sat;
        for (int n = 0; n < 4; n++) begin
            sm = r3_mf_hi[n];
            sm = (sm <<< 26) + r3_mf_lo[n];
            sl = r3_lf_hi[n];
            sl = (sl <<< 26) + r3_lf_lo[n];
            sa = (sm <<< 2) + (sl <<< 1);
            rs = round_sat(sa, 36);
            n4_item.stress[n] = rs.val;
            n4_item.ssat[n]   = rs.sat;
        end
        n4_item.f   = r3_f;
        n4_item.e00 = r3_e00;
        n4_item.e01 = r3_e01;
        n4_item.e11 = r3_e11;
        n4_item.b00 = r3_b00;
        n4_item.b01 = r3_b01;
        n4_item.b11 = r3_b11;
        n4_item.tr  = r3_tr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_f <= i_data;
            r1_f <= r0_f;
            r1_e00 <= n1_e00; r1_e01 <= n1_e01; r1_e11 <= n1_e11;
            r1_b00 <= n1_b00; r1_b01 <= n1_b01; r1_b11 <= n1_b11;
            r2_f <= r1_f;
            r2_e00 <= r1_e00; r2_e01 <= r1_e01; r2_e11 <= r1_e11;
            r2_b00 <= r1_b00; r2_b01 <= r1_b01; r2_b11 <= r1_b11;
            r2_tr  <= n2_tr;
            r2_tsq <= n2_tsq;
            r2_ssq <= n2_ssq;
            r2_fe  <= n2_fe;
            r2_tf  <= n2_tf;
            r3_f <= r2_f;
            r3_e00 <= r2_e00; r3_e01 <= r2_e01; r3_e11 <= r2_e11;
            r3_b00 <= r2_b00; r3_b01 <= r2_b01; r3_b11 <= r2_b11;
            r3_tr    <= r2_tr;
            r3_lt_hi <= n3_lt_hi; r3_lt_lo <= n3_lt_lo;
            r3_ms_hi <= n3_ms_hi; r3_ms_lo <= n3_ms_lo;
            r3_mf_hi <= n3_mf_hi; r3_mf_lo <= n3_mf_lo;
            r3_lf_hi <= n3_lf_hi; r3_lf_lo <= n3_lf_lo;
            r4_item  <= n4_item;
        end
    end
endmodule
`default_nettype wire

### rtl/core/stvk_back.sv
// stvk_back: steps through the four hessian columns of each queued item
// depends on stvk_pkg
`timescale 1ns / 1ps
`default_nettype none
module stvk_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  stvk_pkg::t_cfg      i_cfg,
    input  stvk_pkg::t_item     i_item,
    input  wire logic           i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire logic           i_ready,
    output logic [1:0]          o_col,
    output logic [3:0][47:0]    o_hess,
    output logic [47:0]         o_stress,
    output logic [47:0]         o_energy,
    output logic                o_sat,
    output logic                o_last
);
    import stvk_pkg::*;

    logic en, iss;
    logic [1:0] r_col;
    logic r1_v, r2_v, r_ov;

    logic signed [35:0] r1_x [4];
    logic signed [37:0] r1_y [4];
    logic signed [60:0] r2_mx [4];
    logic signed [62:0] r2_ly [4];
    logic [1:0]  r1_col, r2_col, r_ocol;
    logic [47:0] r1_en, r2_en, r_oen, r1_st, r2_st, r_ost;
    logic        r1_sat, r2_sat, r_osat;
    logic [3:0][47:0] r_ohess;

    logic signed [35:0] n1_x [4];
    logic signed [37:0] n1_y [4];
    logic [3:0][47:0] n_hess;
    logic n_sat;

    logic signed [24:0] cl, cm;
    assign cl = $signed({1'b0, i_cfg.lam});
    assign cm = $signed({1'b0, i_cfg.mu});

    assign en    = !r_ov || i_ready;
    assign iss   = en && !i_empty;
    assign o_pop = iss && (r_col == COL_LAST);

    function automatic logic signed [15:0] fsel(input t_item it, input logic i, input logic j);
        return $signed(it.f[{j, i}]);
    endfunction

    function automatic logic signed [33:0] esel(input t_item it, input logic l, input logic j);
        if (l != j) return it.e01;
        return l ? it.e11 : it.e00;
    endfunction

    function automatic logic signed [33:0] bsel(input t_item it, input logic i, input logic k);
        if (i != k) return it.b01;
        return i ? it.b11 : it.b00;
    endfunction

    // per row a = i + 2*j of column c = k + 2*l
    always_comb begin
        logic i, j, k, l;
        logic signed [31:0] px, py;
        logic signed [35:0] xs;
        logic signed [37:0] ys;
        k = r_col[0];
        l = r_col[1];
        for (int a = 0; a < 4; a++) begin
            i  = a[0];
            j  = a[1];
            px = fsel(i_item, i, l) * fsel(i_item, k, j);
            py = fsel(i_item, k, l) * fsel(i_item, i, j);
            xs = px;
            if (i == k) xs = xs + esel(i_item, l, j);
            if (j == l) xs = xs + bsel(i_item, i, k);
            ys = py;
            ys = ys <<< 2;
            if (i == k && j == l) ys = ys + i_item.tr + i_item.tr;
            n1_x[a] = xs;
            n1_y[a] = ys;
        end
    end

    always_comb begin
        logic signed [67:0] acc;
        t_rs rs;
        n_sat = r2_sat;
        for (int a = 0; a < 4; a++) begin
            acc = r2_mx[a];
            acc = (acc <<< 2) + r2_ly[a];
            rs = round_sat(acc, 24);
            n_hess[a] = rs.val;
            n_sat = n_sat | rs.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r_ov  <= 1'b0;
        end else if (en) begin
            if (iss) r_col <= r_col + 1'b1;
            r1_v <= iss;
            r2_v <= r1_v;
            r_ov <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x   <= n1_x;
            r1_y   <= n1_y;
            r1_col <= r_col;
            r1_en  <= i_item.energy;
            r1_st  <= i_item.stress[r_col];
            r1_sat <= i_item.esat | i_item.ssat[r_col];
            for (int a = 0; a < 4; a++) begin
                r2_mx[a] <= r1_x[a] * cm;
                r2_ly[a] <= r1_y[a] * cl;
            end
            r2_col  <= r1_col;
            r2_en   <= r1_en;
            r2_st   <= r1_st;
            r2_sat  <= r1_sat;
            r_ohess <= n_hess;
            r_ocol  <= r2_col;
            r_oen   <= r2_en;
            r_ost   <= r2_st;
            r_osat  <= n_sat;
        end
    end

    assign o_valid  = r_ov;
    assign o_col    = r_ocol;
    assign o_hess   = r_ohess;
    assign o_stress = r_ost;
    assign o_energy = r_oen;
    assign o_sat    = r_osat;
    assign o_last   = (r_ocol == COL_LAST);
endmodule
`default_nettype wire

### rtl/core/stvk_checker.sv
// stvk_checker: port-level checks on the output stream of the top level
// depends on stvk_pkg and stvk_energy_stress_hessian_2d, bound below
`timescale 1ns / 1ps
`default_nettype none
module stvk_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           o_m_tvalid,
    input wire logic           i_m_tready,
    input wire logic [295:0]   o_m_tdata,
    input wire logic           o_m_tlast
);
    import stvk_pkg::*;

    logic [1:0] r_exp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_exp <= '0;
        else if (o_m_tvalid && i_m_tready) r_exp <= r_exp + 1'b1;
    end

    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_last_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tlast == (o_m_tdata[1:0] == COL_LAST)))
        else $error("tlast not on column 3");

    a_col_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] == r_exp))
        else $error("columns out of order");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled beat changed");
endmodule

bind stvk_energy_stress_hessian_2d stvk_checker u_chk (.*);
`default_nettype wire
